// ===== design/arpc_pkg.sv =====
// shared widths, opcodes and status codes of the arp cache
package arpc_pkg;

   localparam int IP_W     = 32;
   localparam int MAC_W    = 48;
   localparam int STATUS_W = 3;
   localparam int IDX_OUT_W = 3;
   localparam int WORD_W   = IP_W + MAC_W;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_LEARN  = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_HIT       = 3'd0,
      STATUS_MISS      = 3'd1,
      STATUS_REFRESHED = 3'd2,
      STATUS_INSERTED  = 3'd3,
      STATUS_DROPPED   = 3'd4
   } status_type;

endpackage

// ===== design/arp_cache_learn_lookup_top.sv =====
// top level of the arp cache: table memory plus scan sequencer
//
// A fully associative cache of ENTRIES bindings from IPv4 address to MAC.
// Request channel (req_): valid/stall, one beat carries opcode (lookup or
// learn), ip_address and mac_address. Response channel (rsp_): valid/stall,
// one beat per request with status, mac_found and entry_index.
// Each request scans the table memory one entry per cycle through its single
// read port, then writes back on a refresh or insert. The memory scan sets
// the pace at which requests are taken. Requests are handled one at a time,
// req_stall is high while one is in flight.
// The response sits in an output register; a new request is accepted while
// it waits, and a stalled response holds its beat until taken, which holds
// the next request at its final step.
// Reset clears all valid bits at once, so the table is empty on the first
// cycle after reset; no clearing pass is needed.
module arp_cache_learn_lookup_top #(
   parameter int ENTRIES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [arpc_pkg::IP_W-1:0]      req_ip_address,
   input  logic [arpc_pkg::MAC_W-1:0]     req_mac_address,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [arpc_pkg::STATUS_W-1:0]  rsp_status,
   output logic [arpc_pkg::MAC_W-1:0]     rsp_mac_found,
   output logic [arpc_pkg::IDX_OUT_W-1:0] rsp_entry_index
);
   import arpc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;

   // each word holds {ip, mac}
   arpc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   arpc_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_ip_address  (req_ip_address),
      .req_mac_address (req_mac_address),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_mac_found   (rsp_mac_found),
      .rsp_entry_index (rsp_entry_index),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data)
   );

endmodule

// ===== design/arpc_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module arpc_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/arpc_ctrl.sv =====
// sequencer: scans the table memory, keeps valid bits, writes back and drives results
module arpc_ctrl #(
   parameter int ENTRIES = 8
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  logic                                         req_opcode,
   input  logic [arpc_pkg::IP_W-1:0]                    req_ip_address,
   input  logic [arpc_pkg::MAC_W-1:0]                   req_mac_address,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic [arpc_pkg::STATUS_W-1:0]                rsp_status,
   output logic [arpc_pkg::MAC_W-1:0]                   rsp_mac_found,
   output logic [arpc_pkg::IDX_OUT_W-1:0]               rsp_entry_index,
   output logic                                         ram_rd_en,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] ram_rd_addr,
   input  logic [arpc_pkg::WORD_W-1:0]                  ram_rd_data,
   output logic                                         ram_wr_en,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] ram_wr_addr,
   output logic [arpc_pkg::WORD_W-1:0]                  ram_wr_data
);
   import arpc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [MAC_W-1:0]    hit_mac_ff, hit_mac_in;
   logic                free_ff, free_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [ENTRIES-1:0]  valid_ff, valid_in;

   logic                op_ff;
   logic [IP_W-1:0]     ip_ff;
   logic [MAC_W-1:0]    mac_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [MAC_W-1:0]    rsp_mac_ff, rsp_mac_in;
   logic [IDX_OUT_W-1:0] rsp_idx_ff, rsp_idx_in;

   logic                accept;
   logic                out_free;
   logic [IP_W-1:0]     ent_ip;
   logic [MAC_W-1:0]    ent_mac;
   logic                ent_valid;
   logic [IDX_W-1:0]    res_idx;
   logic [IDX_W+IDX_OUT_W-1:0] res_idx_ext;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign ent_ip    = ram_rd_data[WORD_W-1:MAC_W];
   assign ent_mac   = ram_rd_data[MAC_W-1:0];
   assign ent_valid = valid_ff[rd_idx_ff];

   assign ram_rd_en   = accept || (state_ff == ST_SCAN);
   assign ram_rd_addr = (state_ff == ST_SCAN) ? cnt_ff : '0;

   // result index is the low bits of the entry number
   assign res_idx_ext = {{IDX_OUT_W{1'b0}}, res_idx};

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_mac_in    = hit_mac_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_mac_in    = rsp_mac_ff;
      rsp_idx_in    = rsp_idx_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hit_idx_ff;
      ram_wr_data   = {ip_ff, mac_ff};
      res_idx       = '0;

      // compare the entry read last cycle; lowest match and lowest hole win
      if (rd_pend_ff) begin
         if (ent_valid && (ent_ip == ip_ff) && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = rd_idx_ff;
            hit_mac_in = ent_mac;
         end
         if (!ent_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hit_in     = 1'b0;
               free_in    = 1'b0;
               rd_pend_in = 1'b1;
               rd_idx_in  = '0;
               cnt_in     = IDX_W'(1);
               state_in   = (ENTRIES == 1) ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_pend_in = 1'b1;
            rd_idx_in  = cnt_ff;
            cnt_in     = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mac_in   = '0;
               state_in     = ST_IDLE;
               if (op_ff == OP_LOOKUP) begin
                  if (hit_ff) begin
                     rsp_status_in = STATUS_HIT;
                     rsp_mac_in    = hit_mac_ff;
                     res_idx       = hit_idx_ff;
                  end else begin
                     rsp_status_in = STATUS_MISS;
                  end
               end else if (hit_ff) begin
                  rsp_status_in = STATUS_REFRESHED;
                  res_idx       = hit_idx_ff;
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = hit_idx_ff;
               end else if (free_ff) begin
                  rsp_status_in         = STATUS_INSERTED;
                  res_idx               = free_idx_ff;
                  ram_wr_en             = 1'b1;
                  ram_wr_addr           = free_idx_ff;
                  valid_in[free_idx_ff] = 1'b1;
               end else begin
                  rsp_status_in = STATUS_DROPPED;
               end
               rsp_idx_in = res_idx_ext[IDX_OUT_W-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_pend_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         rd_idx_ff     <= '0;
         rsp_status_ff <= STATUS_MISS;
         rsp_mac_ff    <= '0;
         rsp_idx_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         rd_pend_ff    <= rd_pend_in;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
         rd_idx_ff     <= rd_idx_in;
         rsp_status_ff <= rsp_status_in;
         rsp_mac_ff    <= rsp_mac_in;
         rsp_idx_ff    <= rsp_idx_in;
      end
   end

   // request payload and scan results
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_opcode;
         ip_ff  <= req_ip_address;
         mac_ff <= req_mac_address;
      end
      hit_idx_ff  <= hit_idx_in;
      hit_mac_ff  <= hit_mac_in;
      free_idx_ff <= free_idx_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_mac_found   = rsp_mac_ff;
   assign rsp_entry_index = rsp_idx_ff;

endmodule
